// ===== src/csag_pkg.sv =====
// Shared types and constants of the chunk sample address generator.
package csag_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned NumDims = 4;

  localparam logic [CfgIdxW-1:0] RegRandomMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSeed       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegChunks     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDim0       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDim1       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDim2       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDim3       = 3'd6;

  localparam logic [63:0] XsMult      = 64'd2685821657736338717;
  localparam logic [63:0] SeedDefault = 64'hDEADBEEFCAFEBABE;
  localparam int unsigned XsShiftA = 12;
  localparam int unsigned XsShiftB = 25;
  localparam int unsigned XsShiftC = 27;

  typedef enum logic {
    AluMul,
    AluDiv
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

// ===== src/csag_if.sv =====
// Valid/ready channel interfaces for request and address words.
interface csag_req_if;
  logic valid;
  logic ready;
  logic sample_request;
  modport source (output valid, output sample_request, input ready);
  modport sink (input valid, input sample_request, output ready);
endinterface

interface csag_addr_if;
  logic        valid;
  logic        ready;
  logic [15:0] coord_0;
  logic [15:0] coord_1;
  logic [15:0] coord_2;
  logic [15:0] coord_3;
  logic [63:0] linear_index;
  logic        last_of_sample;
  modport source (output valid, output coord_0, output coord_1, output coord_2,
                  output coord_3, output linear_index, output last_of_sample,
                  input ready);
  modport sink (input valid, input coord_0, input coord_1, input coord_2,
                input coord_3, input linear_index, input last_of_sample,
                output ready);
endinterface

// ===== src/chunk_sample_address_generator_top.sv =====
// Top level: configuration, sequencer and address run output.
//
// Use: req_i takes one request word; a word with sample_request set starts a
// run of address words on res_o, one per configured chunk (1 if 0, at most
// MAX_CHUNKS_PER_SAMPLE), the last flagged by last_of_sample. A word with
// sample_request clear is taken and dropped.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle; writing the seed reloads the generator.
// Sequence: a request makes 8 passes through the shared 64-step multiply/divide
// unit in either mode (3 for the chunk total, the draw multiply or the cursor
// update, start mod total, 3 coordinate splits); then the first address word
// is loaded, and after that one address word per cycle, while res_o.ready
// allows, from a mixed-radix counter.
// req_i.ready is high only while no request is in work; the output register
// lets a new request be taken while the last word still waits.
// When res_o.ready is low the current word holds and the run pauses.
// Reset: mode sequential, seed zero (default generator state), one chunk per
// sample, all dimensions 1, cursor zero.
module chunk_sample_address_generator_top #(
  parameter int unsigned MAX_RANK = 4,
  parameter int unsigned MAX_CHUNKS_PER_SAMPLE = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  csag_req_if.sink                            req_i,
  csag_addr_if.source                         res_o,
  input  logic                                cfg_we_i,
  input  logic [csag_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [csag_pkg::CfgDataW-1:0]       cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_TOT1, S_TOT2, S_TOT3, S_DRAW, S_MODS, S_CUR,
    S_DEC3, S_DEC2, S_DEC1, S_GEN
  } state_e;

  localparam logic [6:0] MaxRun = 7'(MAX_CHUNKS_PER_SAMPLE);

  state_e       state_q;
  logic         random_q;
  logic [63:0]  gen_q;
  logic [6:0]   cps_q;
  logic [15:0]  dim_q [csag_pkg::NumDims];
  logic [15:0]  dim_eff [csag_pkg::NumDims];
  logic [63:0]  cursor_q;
  logic [63:0]  total_q;
  logic [63:0]  start_q;
  logic [6:0]   n_q;
  logic [6:0]   c_q;
  logic [63:0]  lin_q;
  logic [15:0]  cur_q [csag_pkg::NumDims];
  logic [15:0]  nxt [csag_pkg::NumDims];
  logic         carry [csag_pkg::NumDims+1];

  logic               out_valid_q;
  logic [15:0]        out_coord_q [csag_pkg::NumDims];
  logic [63:0]        out_lin_q;
  logic               out_last_q;

  csag_pkg::alu_req_t alu_req_q;
  logic [63:0]        alu_a_q;
  logic [63:0]        alu_b_q;
  logic               alu_done;
  logic [63:0]        alu_res;
  logic [63:0]        alu_rem;

  logic [63:0] xs1, xs2, xs3;
  logic [6:0]  run_len;
  logic        load_out;
  logic        is_last;

  csag_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req_q),
    .a_i      (alu_a_q),
    .b_i      (alu_b_q),
    .done_o   (alu_done),
    .result_o (alu_res),
    .rem_o    (alu_rem)
  );

  always_comb begin
    for (int d = 0; d < csag_pkg::NumDims; d++) begin
      if (d >= MAX_RANK || dim_q[d] == 16'd0) dim_eff[d] = 16'd1;
      else dim_eff[d] = dim_q[d];
    end
  end

  // mixed-radix increment, last dimension fastest
  always_comb begin
    carry[csag_pkg::NumDims] = 1'b1;
    for (int d = csag_pkg::NumDims - 1; d >= 0; d--) begin
      if (carry[d+1]) begin
        if (cur_q[d] == dim_eff[d] - 16'd1) begin
          nxt[d]   = 16'd0;
          carry[d] = 1'b1;
        end else begin
          nxt[d]   = cur_q[d] + 16'd1;
          carry[d] = 1'b0;
        end
      end else begin
        nxt[d]   = cur_q[d];
        carry[d] = 1'b0;
      end
    end
  end

  assign xs1 = gen_q ^ (gen_q >> csag_pkg::XsShiftA);
  assign xs2 = xs1 ^ (xs1 << csag_pkg::XsShiftB);
  assign xs3 = xs2 ^ (xs2 >> csag_pkg::XsShiftC);

  always_comb begin
    if (cps_q == 7'd0) run_len = 7'd1;
    else if (cps_q > MaxRun) run_len = MaxRun;
    else run_len = cps_q;
  end

  assign load_out = (state_q == S_GEN) && (!out_valid_q || res_o.ready);
  assign is_last  = (c_q == n_q - 7'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      random_q    <= 1'b0;
      gen_q       <= csag_pkg::SeedDefault;
      cps_q       <= 7'd1;
      for (int d = 0; d < csag_pkg::NumDims; d++) dim_q[d] <= 16'd1;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
      alu_req_q   <= '{start: 1'b0, op: csag_pkg::AluMul};
    end else begin
      if (alu_req_q.start) alu_req_q.start <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          csag_pkg::RegRandomMode: random_q <= cfg_data_i[0];
          csag_pkg::RegSeed:
            gen_q <= (cfg_data_i == 64'd0) ? csag_pkg::SeedDefault : cfg_data_i;
          csag_pkg::RegChunks: cps_q <= cfg_data_i[6:0];
          csag_pkg::RegDim0: dim_q[0] <= cfg_data_i[15:0];
          csag_pkg::RegDim1: dim_q[1] <= cfg_data_i[15:0];
          csag_pkg::RegDim2: dim_q[2] <= cfg_data_i[15:0];
          csag_pkg::RegDim3: dim_q[3] <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (res_o.ready && !load_out) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.sample_request) begin
            n_q       <= run_len;
            alu_req_q <= '{start: 1'b1, op: csag_pkg::AluMul};
            alu_a_q   <= {48'd0, dim_eff[0]};
            alu_b_q   <= {48'd0, dim_eff[1]};
            state_q   <= S_TOT1;
          end
        end
        S_TOT1: begin
          if (alu_done) begin
            alu_req_q <= '{start: 1'b1, op: csag_pkg::AluMul};
            alu_a_q   <= alu_res;
            alu_b_q   <= {48'd0, dim_eff[2]};
            state_q   <= S_TOT2;
          end
        end
        S_TOT2: begin
          if (alu_done) begin
            alu_req_q <= '{start: 1'b1, op: csag_pkg::AluMul};
            alu_a_q   <= alu_res;
            alu_b_q   <= {48'd0, dim_eff[3]};
            state_q   <= S_TOT3;
          end
        end
        S_TOT3: begin
          if (alu_done) begin
            total_q <= alu_res;
            if (random_q) begin
              gen_q     <= xs3;
              alu_req_q <= '{start: 1'b1, op: csag_pkg::AluMul};
              alu_a_q   <= xs3;
              alu_b_q   <= csag_pkg::XsMult;
              state_q   <= S_DRAW;
            end else begin
              alu_req_q <= '{start: 1'b1, op: csag_pkg::AluDiv};
              alu_a_q   <= cursor_q;
              alu_b_q   <= alu_res;
              state_q   <= S_MODS;
            end
          end
        end
        S_DRAW: begin
          if (alu_done) begin
            alu_req_q <= '{start: 1'b1, op: csag_pkg::AluDiv};
            alu_a_q   <= alu_res;
            alu_b_q   <= total_q;
            state_q   <= S_MODS;
          end
        end
        S_MODS: begin
          if (alu_done) begin
            start_q <= alu_rem;
            if (random_q) begin
              alu_req_q <= '{start: 1'b1, op: csag_pkg::AluDiv};
              alu_a_q   <= alu_rem;
              alu_b_q   <= {48'd0, dim_eff[3]};
              state_q   <= S_DEC3;
            end else begin
              alu_req_q <= '{start: 1'b1, op: csag_pkg::AluDiv};
              alu_a_q   <= alu_rem + {57'd0, n_q};
              alu_b_q   <= total_q;
              state_q   <= S_CUR;
            end
          end
        end
        S_CUR: begin
          if (alu_done) begin
            cursor_q  <= alu_rem;
            alu_req_q <= '{start: 1'b1, op: csag_pkg::AluDiv};
            alu_a_q   <= start_q;
            alu_b_q   <= {48'd0, dim_eff[3]};
            state_q   <= S_DEC3;
          end
        end
        S_DEC3: begin
          if (alu_done) begin
            cur_q[3]  <= alu_rem[15:0];
            alu_req_q <= '{start: 1'b1, op: csag_pkg::AluDiv};
            alu_a_q   <= alu_res;
            alu_b_q   <= {48'd0, dim_eff[2]};
            state_q   <= S_DEC2;
          end
        end
        S_DEC2: begin
          if (alu_done) begin
            cur_q[2]  <= alu_rem[15:0];
            alu_req_q <= '{start: 1'b1, op: csag_pkg::AluDiv};
            alu_a_q   <= alu_res;
            alu_b_q   <= {48'd0, dim_eff[1]};
            state_q   <= S_DEC1;
          end
        end
        S_DEC1: begin
          if (alu_done) begin
            cur_q[1] <= alu_rem[15:0];
            cur_q[0] <= alu_res[15:0];
            lin_q    <= start_q;
            c_q      <= 7'd0;
            state_q  <= S_GEN;
          end
        end
        S_GEN: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            for (int d = 0; d < csag_pkg::NumDims; d++) out_coord_q[d] <= cur_q[d];
            out_lin_q  <= lin_q;
            out_last_q <= is_last;
            c_q        <= c_q + 7'd1;
            if (lin_q == total_q - 64'd1) begin
              lin_q <= '0;
              for (int d = 0; d < csag_pkg::NumDims; d++) cur_q[d] <= 16'd0;
            end else begin
              lin_q <= lin_q + 64'd1;
              for (int d = 0; d < csag_pkg::NumDims; d++) cur_q[d] <= nxt[d];
            end
            if (is_last) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign res_o.valid          = out_valid_q;
  assign res_o.coord_0        = out_coord_q[0];
  assign res_o.coord_1        = out_coord_q[1];
  assign res_o.coord_2        = out_coord_q[2];
  assign res_o.coord_3        = out_coord_q[3];
  assign res_o.linear_index   = out_lin_q;
  assign res_o.last_of_sample = out_last_q;

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q != S_IDLE && state_q != S_GEN))
    else $error("unit finished outside a wait state");
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && is_last) |=> (state_q != S_GEN))
    else $error("run continued after last word");
  a_gen_needs_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GEN && $past(state_q) != S_GEN) |-> $past(alu_done))
    else $error("run started without coordinate split");
`endif

endmodule

// ===== src/csag_alu.sv =====
// Shared bit-serial unit: 64-bit shift-add multiply and restoring divide.
module csag_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csag_pkg::alu_req_t  req_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  output logic                done_o,
  output logic [63:0]         result_o,
  output logic [63:0]         rem_o
);

  logic [63:0]       x_q;
  logic [63:0]       y_q;
  logic [64:0]       acc_q;
  logic [5:0]        cnt_q;
  logic              run_q;
  logic              done_q;
  csag_pkg::alu_op_e op_q;
  logic [64:0]       trial;
  logic [64:0]       diff;

  assign trial = {acc_q[63:0], x_q[63]};
  assign diff  = trial - {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= csag_pkg::AluMul;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        x_q   <= a_i;
        y_q   <= b_i;
        acc_q <= '0;
        cnt_q <= '0;
        op_q  <= req_i.op;
        run_q <= 1'b1;
      end else if (run_q) begin
        if (op_q == csag_pkg::AluMul) begin
          acc_q <= {1'b0, acc_q[63:0] + (y_q[0] ? x_q : 64'd0)};
          x_q   <= {x_q[62:0], 1'b0};
          y_q   <= {1'b0, y_q[63:1]};
        end else begin
          if (!diff[64]) begin
            acc_q <= diff;
            x_q   <= {x_q[62:0], 1'b1};
          end else begin
            acc_q <= trial;
            x_q   <= {x_q[62:0], 1'b0};
          end
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = (op_q == csag_pkg::AluMul) ? acc_q[63:0] : x_q;
  assign rem_o    = acc_q[63:0];

endmodule

// ===== test/chunk_sample_address_generator_top_test.sv =====
// Testbench for the chunk sample address generator: random requests, scoreboard check.
`timescale 1ns / 100ps

class chunk_addr_board;
  bit        random_mode;
  bit [63:0] seed;
  bit [6:0]  run_cfg;
  bit [15:0] dim_cnt [4];
  bit [63:0] gen_state;
  bit [63:0] cursor;
  bit [3:0][15:0] exp_coord [$];
  bit [63:0] exp_lin [$];
  bit        exp_last [$];
  int        errors;

  function new();
    random_mode = 0;
    seed = 0;
    run_cfg = 1;
    foreach (dim_cnt[d]) dim_cnt[d] = 1;
    gen_state = csag_pkg::SeedDefault;
    cursor = 0;
    errors = 0;
  endfunction

  function bit [63:0] dim_size(int d);
    return (dim_cnt[d] == 0) ? 64'd1 : 64'(dim_cnt[d]);
  endfunction

  function void write_reg(bit [2:0] idx, bit [63:0] val);
    case (idx)
      csag_pkg::RegRandomMode: random_mode = val[0];
      csag_pkg::RegSeed: begin
        seed = val;
        gen_state = (val != 0) ? val : csag_pkg::SeedDefault;
      end
      csag_pkg::RegChunks: run_cfg = val[6:0];
      csag_pkg::RegDim0, csag_pkg::RegDim1, csag_pkg::RegDim2, csag_pkg::RegDim3:
        dim_cnt[idx - csag_pkg::RegDim0] = val[15:0];
      default: ;
    endcase
  endfunction

  function void note_request(bit req);
    bit [63:0] total, n, start, lin, rest, x;
    bit [3:0][15:0] crd;
    if (!req) return;
    total = 64'd1;
    for (int d = 0; d < 4; d++) total = total * dim_size(d);
    if (run_cfg == 0) n = 64'd1;
    else if (run_cfg > 64) n = 64'd64;
    else n = 64'(run_cfg);
    if (random_mode) begin
      x = gen_state;
      x ^= x >> 12;
      x ^= x << 25;
      x ^= x >> 27;
      gen_state = x;
      start = (x * csag_pkg::XsMult) % total;
    end else begin
      start = cursor;
      cursor = (cursor % total + n) % total;
    end
    for (bit [63:0] c = 0; c < n; c++) begin
      lin = (start % total + c) % total;
      rest = lin;
      for (int d = 3; d >= 0; d--) begin
        crd[d] = 16'(rest % dim_size(d));
        rest = rest / dim_size(d);
      end
      exp_coord.push_back(crd);
      exp_lin.push_back(lin);
      exp_last.push_back(c + 1 == n);
    end
  endfunction

  task check_word(bit [15:0] c0, bit [15:0] c1, bit [15:0] c2, bit [15:0] c3,
                  bit [63:0] lin, bit last);
    bit [3:0][15:0] e;
    bit [63:0] el;
    bit        elast;
    if (exp_lin.size() == 0) begin
      report("address word with none expected");
      return;
    end
    e = exp_coord.pop_front();
    el = exp_lin.pop_front();
    elast = exp_last.pop_front();
    if (c0 != e[0]) report($sformatf("coord_0 %0d exp %0d", c0, e[0]));
    if (c1 != e[1]) report($sformatf("coord_1 %0d exp %0d", c1, e[1]));
    if (c2 != e[2]) report($sformatf("coord_2 %0d exp %0d", c2, e[2]));
    if (c3 != e[3]) report($sformatf("coord_3 %0d exp %0d", c3, e[3]));
    if (lin != el) report($sformatf("linear_index %0d exp %0d", lin, el));
    if (last != elast) report($sformatf("last_of_sample %0b exp %0b", last, elast));
  endtask

  task report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask
endclass

module chunk_sample_address_generator_top_test;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [csag_pkg::CfgIdxW-1:0] cfg_idx_i = csag_pkg::RegRandomMode;
  logic [csag_pkg::CfgDataW-1:0] cfg_data_i = '0;
  csag_req_if req_i ();
  csag_addr_if res_o ();
  chunk_addr_board board = new();
  int cycles = 0;
  bit quiet = 0;
  int sent = 0;

  chunk_sample_address_generator_top dut (
    .clk_i, .rst_ni, .req_i(req_i.sink), .res_o(res_o.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (req_i.valid && req_i.ready) board.note_request(req_i.sample_request);
    if (res_o.valid && res_o.ready)
      board.check_word(res_o.coord_0, res_o.coord_1, res_o.coord_2, res_o.coord_3,
                       res_o.linear_index, res_o.last_of_sample);
  end

  // receiver: random stall bursts
  initial begin
    int k;
    res_o.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        res_o.ready <= 0;
        k = $urandom_range(1, 19);
        repeat (k) @(negedge clk_i);
      end
      res_o.ready <= 1;
    end
  end

  task automatic cfg_write(logic [csag_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.write_reg(idx, val);
  endtask

  task automatic wait_idle();
    while (board.exp_lin.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic send(bit req);
    int k;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      k = $urandom_range(1, 19);
      repeat (k) @(negedge clk_i);
    end
    req_i.valid <= 1;
    req_i.sample_request <= req;
    @(posedge clk_i);
    while (!req_i.ready) @(posedge clk_i);
    @(negedge clk_i);
    req_i.valid <= 0;
    sent++;
  endtask

  task automatic set_dims(bit [15:0] d0, bit [15:0] d1, bit [15:0] d2, bit [15:0] d3);
    cfg_write(csag_pkg::RegDim0, 64'(d0));
    cfg_write(csag_pkg::RegDim1, 64'(d1));
    cfg_write(csag_pkg::RegDim2, 64'(d2));
    cfg_write(csag_pkg::RegDim3, 64'(d3));
  endtask

  function automatic bit [15:0] rdim();
    case ($urandom_range(0, 5))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'd0;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin
    req_i.valid = 0;
    req_i.sample_request = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    // directed
    send(1); send(0); send(1);
    wait_idle();
    set_dims(16'd3, 16'd1, 16'd4, 16'd5);
    cfg_write(csag_pkg::RegChunks, 64'd7);
    repeat (3) send(1);
    wait_idle();
    cfg_write(csag_pkg::RegChunks, 64'd64);
    set_dims(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(1); send(1);
    wait_idle();
    cfg_write(csag_pkg::RegRandomMode, 64'd1);
    cfg_write(csag_pkg::RegSeed, 64'd0);
    cfg_write(csag_pkg::RegChunks, 64'd0);
    send(1); send(1);
    wait_idle();
    cfg_write(csag_pkg::RegSeed, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(csag_pkg::RegChunks, 64'd127);
    set_dims(16'd0, 16'd2, 16'd0, 16'd7);
    send(1); send(0); send(1);
    wait_idle();
    cfg_write(csag_pkg::RegDim2, 64'd9);
    cfg_write(csag_pkg::RegChunks, 64'd100);
    send(1);
    wait_idle();
    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      if (ph >= 10) quiet = 1;
      cfg_write(csag_pkg::RegRandomMode, 64'($urandom_range(0, 1)));
      cfg_write(csag_pkg::RegSeed, {$urandom, $urandom});
      cfg_write(csag_pkg::RegChunks,
                ($urandom_range(0, 3) == 0) ? 64'd64 : 64'($urandom_range(0, 20)));
      set_dims(rdim(), rdim(), rdim(), rdim());
      for (int i = 0; i < 25; i++) begin
        send($urandom_range(0, 9) != 0);
        if (i == 12 && ph == 3) while (board.exp_lin.size() != 0) @(negedge clk_i);
      end
      wait_idle();
    end
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
